### rtl/ptc_pkg.sv
// Shared types, constants and helper functions of the sensor compensation pipeline.
package ptc_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [15:0]        pressure;
        logic               pressure_valid;
        logic [16:0]        humidity;
        logic               humidity_valid;
    } result_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_low;
        logic [63:0] press_high;
        logic [15:0] press_nine;
        logic [63:0] humid;
        logic        humid_enable;
    } coeffs_t;

    // Flags that ride along the divider stages.
    typedef struct packed {
        logic zero;
        logic shift;
    } div_side_t;

    typedef enum logic [2:0] {
        REG_TEMP_COEFFS      = 3'd0,
        REG_PRESS_COEFFS_LOW = 3'd1,
        REG_PRESS_COEFFS_HI  = 3'd2,
        REG_PRESS_COEFF_NINE = 3'd3,
        REG_HUMID_COEFFS     = 3'd4,
        REG_HUMID_ENABLE     = 3'd5
    } reg_index_t;

    localparam int TEMP_LAT  = 4;
    localparam int PRE_LAT   = 7;
    localparam int DIV_LAT   = 32;
    localparam int POST_LAT  = 5;
    localparam int PRESS_LAT = PRE_LAT + DIV_LAT + POST_LAT;
    localparam int HUM_LAT   = 7;
    localparam int TOTAL_LAT = TEMP_LAT + PRESS_LAT;

    localparam logic [31:0] TF_PRESS_OFFSET = 32'd64000;
    localparam logic [31:0] PRESS_FULL      = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE     = 32'd3125;
    localparam logic [31:0] PRESS_ROUND     = 32'd32768;
    localparam logic [31:0] TF_HUM_OFFSET   = 32'd76800;
    localparam logic [31:0] HUM_ROUND       = 32'd16384;
    localparam logic [31:0] HUM_B_OFFSET    = 32'd2097152;
    localparam logic [31:0] HUM_B_ROUND     = 32'd8192;
    localparam logic [31:0] HUM_LIMIT       = 32'd419430400;
    localparam logic [15:0] HUM_SENTINEL    = 16'h8000;
    localparam logic [31:0] RECIP_TEN       = 32'hCCCCCCCD;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] x);
        return {{20{x[11]}}, x};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] x);
        return {{24{x[7]}}, x};
    endfunction

endpackage

### rtl/ptc_temp.sv
// Temperature pipeline: fine temperature and saturated temperature in four stages.
module ptc_temp
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sample_t            in_sample,
    input  coeffs_t            coeffs,
    output logic               out_valid,
    output sample_t            out_sample,
    output logic [31:0]        out_tf,
    output logic signed [15:0] out_temp
);

    logic [TEMP_LAT-1:0] valid_reg;
    sample_t     smp_reg [TEMP_LAT];
    logic [31:0] m1_reg, dd_reg, v1_reg, m2_reg, tf_reg, tf2_reg;
    logic signed [15:0] temp_reg;

    logic [31:0] t1, t2, t3, adc, a, d, t;

    always_comb
    begin
        t1  = {16'd0, coeffs.temp[15:0]};
        t2  = sx16(coeffs.temp[31:16]);
        t3  = sx16(coeffs.temp[47:32]);
        adc = {12'd0, in_sample.raw_temperature};
        a   = (adc >> 3) - (t1 << 1);
        d   = (adc >> 4) - t1;
        t   = asr((tf_reg << 2) + tf_reg + 32'd128, 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[TEMP_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        smp_reg[0] <= in_sample;
        for (int i = 1; i < TEMP_LAT; i++)
            smp_reg[i] <= smp_reg[i-1];
        m1_reg  <= a * t2;
        dd_reg  <= d * d;
        v1_reg  <= asr(m1_reg, 11);
        m2_reg  <= asr(dd_reg, 12) * t3;
        tf_reg  <= v1_reg + asr(m2_reg, 14);
        tf2_reg <= tf_reg;
        if ($signed(t) < -32'sd32768)
            temp_reg <= -16'sd32768;
        else if ($signed(t) > 32'sd32767)
            temp_reg <= 16'sd32767;
        else
            temp_reg <= $signed(t[15:0]);
    end

    assign out_valid  = valid_reg[TEMP_LAT-1];
    assign out_sample = smp_reg[TEMP_LAT-1];
    assign out_tf     = tf2_reg;
    assign out_temp   = temp_reg;

endmodule

### rtl/ptc_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per pipeline stage.
module ptc_div
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_dividend,
    input  logic [31:0] in_divisor,
    input  div_side_t   in_side,
    output logic        out_valid,
    output logic [31:0] out_quotient,
    output div_side_t   out_side
);

    logic [DIV_LAT-1:0] valid_reg;
    logic [31:0] rem_reg  [DIV_LAT];
    logic [31:0] dvd_reg  [DIV_LAT];
    logic [31:0] den_reg  [DIV_LAT];
    div_side_t   side_reg [DIV_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[DIV_LAT-2:0], in_valid};
    end

    // The dividend register shifts left and collects quotient bits at its bottom.
    for (genvar i = 0; i < DIV_LAT; i++)
    begin : g_stage
        logic [31:0] src_rem, src_dvd, src_den;
        logic [32:0] trial;

        if (i == 0)
        begin : g_first
            assign src_rem = '0;
            assign src_dvd = in_dividend;
            assign src_den = in_divisor;
        end
        else
        begin : g_next
            assign src_rem = rem_reg[i-1];
            assign src_dvd = dvd_reg[i-1];
            assign src_den = den_reg[i-1];
        end

        assign trial = {src_rem, src_dvd[31]} - {1'b0, src_den};

        always_ff @(posedge clk)
        begin
            if (!trial[32])
            begin
                rem_reg[i] <= trial[31:0];
                dvd_reg[i] <= {src_dvd[30:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= {src_rem[30:0], src_dvd[31]};
                dvd_reg[i] <= {src_dvd[30:0], 1'b0};
            end
            den_reg[i]  <= src_den;
            side_reg[i] <= (i == 0) ? in_side : side_reg[(i == 0) ? 0 : i-1];
        end
    end

    assign out_valid    = valid_reg[DIV_LAT-1];
    assign out_quotient = dvd_reg[DIV_LAT-1];
    assign out_side     = side_reg[DIV_LAT-1];

endmodule

### rtl/ptc_press.sv
// Pressure pipeline: coefficient terms, divider and final correction with scaling by ten.
module ptc_press
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_tf,
    input  logic [19:0] in_raw_pressure,
    input  coeffs_t     coeffs,
    output logic        out_valid,
    output logic [15:0] out_pressure,
    output logic        out_pressure_valid
);

    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] v1c, qc, v2c, xc, pd;

    logic [PRE_LAT-1:0]  pre_valid_reg;
    logic [POST_LAT-1:0] post_valid_reg;

    logic [19:0] adc1_reg, adc2_reg, adc3_reg, adc4_reg;
    logic [31:0] v1_reg, sq_reg, m5_reg, m5b_reg, a_reg, b_reg, c_reg;
    logic [31:0] v2_reg, x_reg, y_reg, v2b_reg, den_reg, num_reg, pm_reg, den2_reg;
    logic [31:0] dvd_reg, dsr_reg;
    div_side_t   side_reg;

    logic        div_valid;
    logic [31:0] div_quot;
    div_side_t   div_side;

    logic [31:0] pq1_reg, sq2_reg, m8_reg, pq2_reg, m9_reg, v2q_reg, pf_reg;
    logic [63:0] prod_reg;
    logic        z1_reg, z2_reg, z3_reg, z4_reg;
    logic [15:0] press_reg;
    logic        pvalid_reg;
    logic [28:0] qd;

    always_comb
    begin
        p1  = {16'd0, coeffs.press_low[15:0]};
        p2  = sx16(coeffs.press_low[31:16]);
        p3  = sx16(coeffs.press_low[47:32]);
        p4  = sx16(coeffs.press_low[63:48]);
        p5  = sx16(coeffs.press_high[15:0]);
        p6  = sx16(coeffs.press_high[31:16]);
        p7  = sx16(coeffs.press_high[47:32]);
        p8  = sx16(coeffs.press_high[63:48]);
        p9  = sx16(coeffs.press_nine);
        v1c = asr(in_tf, 1) - TF_PRESS_OFFSET;
        qc  = asr(v1c, 2);
        v2c = asr(a_reg + (m5b_reg << 1), 2) + (p4 << 16);
        xc  = asr(asr(b_reg, 3) + asr(c_reg, 1), 18);
        pd  = div_side.shift ? {div_quot[30:0], 1'b0} : div_quot;
        qd  = prod_reg[63:35];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg  <= '0;
            post_valid_reg <= '0;
        end
        else
        begin
            pre_valid_reg  <= {pre_valid_reg[PRE_LAT-2:0], in_valid};
            post_valid_reg <= {post_valid_reg[POST_LAT-2:0], div_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // Terms ahead of the divider.
        adc1_reg <= in_raw_pressure;
        v1_reg   <= v1c;
        sq_reg   <= qc * qc;
        m5_reg   <= v1c * p5;

        adc2_reg <= adc1_reg;
        a_reg    <= asr(sq_reg, 11) * p6;
        b_reg    <= p3 * asr(sq_reg, 13);
        c_reg    <= p2 * v1_reg;
        m5b_reg  <= m5_reg;

        adc3_reg <= adc2_reg;
        v2_reg   <= v2c;
        x_reg    <= xc;

        adc4_reg <= adc3_reg;
        v2b_reg  <= v2_reg;
        y_reg    <= (PRESS_ROUND + x_reg) * p1;

        den_reg  <= asr(y_reg, 15);
        num_reg  <= (PRESS_FULL - {12'd0, adc4_reg}) - asr(v2b_reg, 12);

        pm_reg   <= num_reg * PRESS_SCALE;
        den2_reg <= den_reg;

        // A product with its top bit set is divided first and doubled afterwards.
        dvd_reg        <= pm_reg[31] ? pm_reg : (pm_reg << 1);
        dsr_reg        <= den2_reg;
        side_reg.shift <= pm_reg[31];
        side_reg.zero  <= (den2_reg == '0);

        // Correction after the divider.
        pq1_reg  <= pd;
        sq2_reg  <= (pd >> 3) * (pd >> 3);
        m8_reg   <= (pd >> 2) * p8;
        z1_reg   <= div_side.zero;

        pq2_reg  <= pq1_reg;
        m9_reg   <= p9 * (sq2_reg >> 13);
        v2q_reg  <= asr(m8_reg, 13);
        z2_reg   <= z1_reg;

        pf_reg   <= pq2_reg + asr(asr(m9_reg, 12) + v2q_reg + p7, 4);
        z3_reg   <= z2_reg;

        prod_reg <= 64'(pf_reg) * 64'(RECIP_TEN);
        z4_reg   <= z3_reg;

        if (z4_reg)
            press_reg <= '0;
        else if (qd > 29'd65535)
            press_reg <= 16'hFFFF;
        else
            press_reg <= qd[15:0];
        pvalid_reg <= !z4_reg;
    end

    ptc_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pre_valid_reg[PRE_LAT-1]),
        .in_dividend  (dvd_reg),
        .in_divisor   (dsr_reg),
        .in_side      (side_reg),
        .out_valid    (div_valid),
        .out_quotient (div_quot),
        .out_side     (div_side)
    );

    assign out_valid          = post_valid_reg[POST_LAT-1];
    assign out_pressure       = press_reg;
    assign out_pressure_valid = pvalid_reg;

endmodule

### rtl/ptc_humid.sv
// Humidity pipeline: seven stages from fine temperature and raw humidity to clamped humidity.
module ptc_humid
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [31:0] in_tf,
    input  logic [15:0] in_raw_humidity,
    input  coeffs_t     coeffs,
    output logic        out_valid,
    output logic [16:0] out_humidity,
    output logic        out_humidity_valid
);

    logic [31:0] h1, h2, h3, h4, h5, h6, vc, bc, wc;

    logic [HUM_LAT-1:0] valid_reg;
    logic [HUM_LAT-2:0] ok_reg;
    logic [15:0] adc_reg;
    logic [31:0] mh5_reg, mh6_reg, mh3_reg, a_reg, bb_reg, a2_reg, mb_reg;
    logic [31:0] v_reg, v2_reg, qq_reg, v3_reg, r_reg;
    logic [16:0] hum_reg;
    logic        hok_reg;

    always_comb
    begin
        h1 = {24'd0, coeffs.humid[7:0]};
        h2 = sx16(coeffs.humid[23:8]);
        h3 = {24'd0, coeffs.humid[31:24]};
        h4 = sx12(coeffs.humid[43:32]);
        h5 = sx12(coeffs.humid[55:44]);
        h6 = sx8(coeffs.humid[63:56]);
        vc = in_tf - TF_HUM_OFFSET;
        bc = asr(mb_reg + HUM_B_ROUND, 14);
        wc = v3_reg - asr(r_reg, 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[HUM_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= {ok_reg[HUM_LAT-3:0],
                    coeffs.humid_enable && (in_raw_humidity != HUM_SENTINEL)};
        adc_reg <= in_raw_humidity;
        mh5_reg <= h5 * vc;
        mh6_reg <= vc * h6;
        mh3_reg <= vc * h3;

        a_reg   <= asr(({16'd0, adc_reg} << 14) - (h4 << 20) - mh5_reg + HUM_ROUND, 15);
        bb_reg  <= asr(mh6_reg, 10) * (asr(mh3_reg, 11) + PRESS_ROUND);

        a2_reg  <= a_reg;
        mb_reg  <= (asr(bb_reg, 10) + HUM_B_OFFSET) * h2;

        v_reg   <= a2_reg * bc;

        v2_reg  <= v_reg;
        qq_reg  <= asr(v_reg, 15) * asr(v_reg, 15);

        v3_reg  <= v2_reg;
        r_reg   <= asr(qq_reg, 7) * h1;

        if (!ok_reg[HUM_LAT-2] || wc[31])
            hum_reg <= '0;
        else if (wc > HUM_LIMIT)
            hum_reg <= HUM_LIMIT[28:12];
        else
            hum_reg <= wc[28:12];
        hok_reg <= ok_reg[HUM_LAT-2];
    end

    assign out_valid          = valid_reg[HUM_LAT-1];
    assign out_humidity       = hum_reg;
    assign out_humidity_valid = hok_reg;

endmodule

### rtl/pressure_temp_humidity_compensation_top.sv
// Top level of the pressure, temperature and humidity compensation pipeline.
//
// A raw sample is taken on every rising edge with start high; busy stays low
// because the datapath is fully pipelined and accepts a new transaction in
// every cycle. Calibration registers are written through write_enable,
// write_index and write_data, and may only change while no transaction is in
// flight. Each sample produces one result on the result port, marked by done
// for exactly one cycle. The pressure path is the longest: 4 temperature
// stages, 7 stages ahead of the divider, the 32-stage bit-per-stage
// divider and 5 stages after it. Temperature and humidity results are
// delayed to line up with pressure. Throughput is one transaction per
// cycle. The receiver cannot stall, so done is a pure strobe and must be
// captured when it is high. Reset clears all calibration registers and all
// pipeline valid bits; results of samples in flight at reset are dropped.
module pressure_temp_humidity_compensation_top
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  sample_t     sample,
    output logic        done,
    output result_t     result,
    input  logic        write_enable,
    input  logic [2:0]  write_index,
    input  logic [63:0] write_data
);

    localparam int HUM_DLY = PRESS_LAT - HUM_LAT;

    coeffs_t coeffs_reg;

    logic               t_valid;
    sample_t            t_sample;
    logic [31:0]        t_tf;
    logic signed [15:0] t_temp;

    logic        p_valid;
    logic [15:0] p_pressure;
    logic        p_ok;

    logic        h_valid;
    logic [16:0] h_humidity;
    logic        h_ok;

    logic signed [15:0] temp_dly_reg [PRESS_LAT];
    logic [16:0]        hum_dly_reg  [HUM_DLY];
    logic [HUM_DLY-1:0] hok_dly_reg;
    logic [HUM_DLY-1:0] hvld_dly_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coeffs_reg <= '0;
        else if (write_enable)
        begin
            unique case (reg_index_t'(write_index))
                REG_TEMP_COEFFS:      coeffs_reg.temp         <= write_data[47:0];
                REG_PRESS_COEFFS_LOW: coeffs_reg.press_low    <= write_data;
                REG_PRESS_COEFFS_HI:  coeffs_reg.press_high   <= write_data;
                REG_PRESS_COEFF_NINE: coeffs_reg.press_nine   <= write_data[15:0];
                REG_HUMID_COEFFS:     coeffs_reg.humid        <= write_data;
                REG_HUMID_ENABLE:     coeffs_reg.humid_enable <= write_data[0];
                default:              coeffs_reg              <= coeffs_reg;
            endcase
        end
    end

    ptc_temp u_temp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .in_sample  (sample),
        .coeffs     (coeffs_reg),
        .out_valid  (t_valid),
        .out_sample (t_sample),
        .out_tf     (t_tf),
        .out_temp   (t_temp)
    );

    ptc_press u_press (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (t_valid),
        .in_tf              (t_tf),
        .in_raw_pressure    (t_sample.raw_pressure),
        .coeffs             (coeffs_reg),
        .out_valid          (p_valid),
        .out_pressure       (p_pressure),
        .out_pressure_valid (p_ok)
    );

    ptc_humid u_humid (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (t_valid),
        .in_tf              (t_tf),
        .in_raw_humidity    (t_sample.raw_humidity),
        .coeffs             (coeffs_reg),
        .out_valid          (h_valid),
        .out_humidity       (h_humidity),
        .out_humidity_valid (h_ok)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hvld_dly_reg <= '0;
        else
            hvld_dly_reg <= {hvld_dly_reg[HUM_DLY-2:0], h_valid};
    end

    always_ff @(posedge clk)
    begin
        temp_dly_reg[0] <= t_temp;
        for (int i = 1; i < PRESS_LAT; i++)
            temp_dly_reg[i] <= temp_dly_reg[i-1];
        hum_dly_reg[0] <= h_humidity;
        for (int i = 1; i < HUM_DLY; i++)
            hum_dly_reg[i] <= hum_dly_reg[i-1];
        hok_dly_reg <= {hok_dly_reg[HUM_DLY-2:0], h_ok};
    end

    assign done                  = p_valid;
    assign result.temperature    = temp_dly_reg[PRESS_LAT-1];
    assign result.pressure       = p_pressure;
    assign result.pressure_valid = p_ok;
    assign result.humidity       = hum_dly_reg[HUM_DLY-1];
    assign result.humidity_valid = hok_dly_reg[HUM_DLY-1];

    // Every result traces back to a transaction accepted one full latency earlier.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL_LAT))
        else $error("result without a matching accepted transaction");

    // The pressure and humidity branches must stay aligned.
    a_branches_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid == hvld_dly_reg[HUM_DLY-1])
        else $error("pressure and humidity pipelines out of step");

    // A sentinel humidity reading never yields a valid humidity.
    a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(sample.raw_humidity, TOTAL_LAT) == HUM_SENTINEL)
        |-> !result.humidity_valid)
        else $error("sentinel humidity reported as valid");

endmodule

### bench/tb.sv
// Self-checking testbench of the sensor compensation pipeline.
module tb;
    import ptc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    sample_t     sample;
    logic        done;
    result_t     result;
    logic        write_enable;
    logic [2:0]  write_index;
    logic [63:0] write_data;

    pressure_temp_humidity_compensation_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample       (sample),
        .done         (done),
        .result       (result),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    // Local copy of the calibration registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_p9;
    logic [63:0] cal_humid;
    logic        cal_humid_en;

    result_t     pending_results[$];
    int          mismatch_count;
    int          unexpected_count;
    int          idle_cycles;
    bit          quiet_stretch;
    bit          timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] shr_s(input logic [31:0] x, input int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] ext(input logic [31:0] x, input int bits);
        logic [31:0] m;
        m = (32'h1 << bits) - 1;
        x = x & m;
        if (x[bits-1])
            x = x | ~m;
        return x;
    endfunction

    function automatic result_t compensate(input sample_t s);
        logic [31:0] adc_t, adc_p, adc_h;
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] v1, v2, d, tf, t, p, q, sq, v, a, b;
        result_t r;
        adc_t = 32'(s.raw_temperature);
        adc_p = 32'(s.raw_pressure);
        adc_h = 32'(s.raw_humidity);
        t1 = 32'(cal_temp[15:0]);
        t2 = ext(32'(cal_temp[31:16]), 16);
        t3 = ext(32'(cal_temp[47:32]), 16);
        p1 = 32'(cal_press_low[15:0]);
        p2 = ext(32'(cal_press_low[31:16]), 16);
        p3 = ext(32'(cal_press_low[47:32]), 16);
        p4 = ext(32'(cal_press_low[63:48]), 16);
        p5 = ext(32'(cal_press_high[15:0]), 16);
        p6 = ext(32'(cal_press_high[31:16]), 16);
        p7 = ext(32'(cal_press_high[47:32]), 16);
        p8 = ext(32'(cal_press_high[63:48]), 16);
        p9 = ext(32'(cal_p9), 16);
        h1 = 32'(cal_humid[7:0]);
        h2 = ext(32'(cal_humid[23:8]), 16);
        h3 = 32'(cal_humid[31:24]);
        h4 = ext(32'(cal_humid[43:32]), 12);
        h5 = ext(32'(cal_humid[55:44]), 12);
        h6 = ext(32'(cal_humid[63:56]), 8);
        r = '0;

        v1 = shr_s(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        d = (adc_t >> 4) - t1;
        v2 = shr_s(shr_s(d * d, 12) * t3, 14);
        tf = v1 + v2;
        t = shr_s(tf * 32'd5 + 32'd128, 8);
        if ($signed(t) < -32768)
            t = 32'hFFFF8000;
        else if ($signed(t) > 32767)
            t = 32'd32767;
        r.temperature = t[15:0];

        v1 = shr_s(tf, 1) - 32'd64000;
        q = shr_s(v1, 2);
        sq = q * q;
        v2 = shr_s(sq, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = shr_s(v2, 2) + (p4 << 16);
        v1 = shr_s(shr_s(p3 * shr_s(sq, 13), 3) + shr_s(p2 * v1, 1), 18);
        v1 = shr_s((32'd32768 + v1) * p1, 15);
        if (v1 != 0)
        begin
            p = ((32'd1048576 - adc_p) - shr_s(v2, 12)) * 32'd3125;
            if (p < 32'h80000000)
                p = (p << 1) / v1;
            else
                p = (p / v1) << 1;
            v1 = shr_s(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = shr_s((p >> 2) * p8, 13);
            p = p + shr_s(v1 + v2 + p7, 4);
            p = p / 32'd10;
            r.pressure = (p > 32'd65535) ? 16'hFFFF : p[15:0];
            r.pressure_valid = 1'b1;
        end

        if (cal_humid_en && adc_h != 32'h8000)
        begin
            v = tf - 32'd76800;
            a = shr_s((adc_h << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
            b = shr_s(v * h6, 10) * (shr_s(v * h3, 11) + 32'd32768);
            b = shr_s(b, 10) + 32'd2097152;
            b = shr_s(b * h2 + 32'd8192, 14);
            v = a * b;
            q = shr_s(v, 15);
            v = v - shr_s(shr_s(q * q, 7) * h1, 4);
            if (v[31])
                v = 0;
            else if (v > 32'd419430400)
                v = 32'd419430400;
            r.humidity = 17'(v >> 12);
            r.humidity_valid = 1'b1;
        end
        return r;
    endfunction

    // Result checker: every strobe must match the oldest pending expectation.
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("Unexpected result %h", result);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display({"Mismatch: exp t=%0d p=%0d pv=%0b h=%0d hv=%0b, ",
                                  "got t=%0d p=%0d pv=%0b h=%0d hv=%0b"},
                            exp_r.temperature, exp_r.pressure, exp_r.pressure_valid,
                            exp_r.humidity, exp_r.humidity_valid,
                            result.temperature, result.pressure, result.pressure_valid,
                            result.humidity, result.humidity_valid);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
        @(posedge clk);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= val;
        case (idx)
            REG_TEMP_COEFFS:      cal_temp = val[47:0];
            REG_PRESS_COEFFS_LOW: cal_press_low = val;
            REG_PRESS_COEFFS_HI:  cal_press_high = val;
            REG_PRESS_COEFF_NINE: cal_p9 = val[15:0];
            REG_HUMID_COEFFS:     cal_humid = val;
            default:              cal_humid_en = val[0];
        endcase
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 4) @(posedge clk);
    endtask

    // Sends one transaction; start stays high when the next call follows directly.
    task automatic send_sample(input sample_t s);
        while (!quiet_stretch && $urandom_range(99) < 8)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= s;
        pending_results.push_back(compensate(s));
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.raw_temperature = 20'($urandom);
        s.raw_pressure    = 20'($urandom);
        s.raw_humidity    = ($urandom_range(15) == 0) ? HUM_SENTINEL : 16'($urandom);
        return s;
    endfunction

    // Typical factory calibration so the formulas land in their normal ranges.
    task automatic load_typical;
        write_reg(REG_TEMP_COEFFS, {16'hFC18, 16'd26435, 16'd27504});
        write_reg(REG_PRESS_COEFFS_LOW, {16'd2855, 16'hD0C5, 16'hD5D4, 16'd36477});
        write_reg(REG_PRESS_COEFFS_HI, {16'hCFC8, 16'h3ABC, 16'hFFF9, 16'd140});
        write_reg(REG_PRESS_COEFF_NINE, 64'd6000);
        write_reg(REG_HUMID_COEFFS, {8'd30, 12'd50, 12'd325, 8'd0, 16'd361, 8'd75});
        write_reg(REG_HUMID_ENABLE, 64'd1);
    endtask

    task automatic test_reset_defaults;
        sample_t s;
        s = '0;
        send_sample(s);
        s = '1;
        send_sample(s);
        drain();
    endtask

    task automatic test_directed;
        sample_t s;
        load_typical();
        s = '{20'd519888, 20'd415148, 16'd30000};
        send_sample(s);
        s = '{20'd0, 20'd0, 16'd0};
        send_sample(s);
        s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF};
        send_sample(s);
        s = '{20'd519888, 20'd0, HUM_SENTINEL};
        send_sample(s);
        s = '{20'hFFFFF, 20'd1, 16'h7FFF};
        send_sample(s);
        s = '{20'd1, 20'hFFFFF, 16'h8001};
        send_sample(s);
        drain();
        // p1 of zero makes the pressure divisor zero.
        write_reg(REG_PRESS_COEFFS_LOW, 64'hD0C5_D5D4_0000_0000 | 64'h0);
        write_reg(REG_HUMID_ENABLE, 64'd0);
        s = '{20'd519888, 20'd415148, 16'd30000};
        send_sample(s);
        s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF};
        send_sample(s);
        drain();
        // Extreme coefficients for saturation and wrap.
        write_reg(REG_TEMP_COEFFS, 64'h7FFF_7FFF_0000);
        write_reg(REG_PRESS_COEFFS_LOW, 64'h8000_8000_8000_FFFF);
        write_reg(REG_PRESS_COEFFS_HI, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_PRESS_COEFF_NINE, 64'h8000);
        write_reg(REG_HUMID_COEFFS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HUMID_ENABLE, 64'd1);
        for (int i = 0; i < 8; i++)
            send_sample(random_sample());
        drain();
        write_reg(REG_TEMP_COEFFS, 64'h8000_8000_FFFF);
        write_reg(REG_PRESS_COEFFS_HI, 64'h8000_8000_8000_8000);
        write_reg(REG_PRESS_COEFF_NINE, 64'h7FFF);
        write_reg(REG_HUMID_COEFFS, 64'h8080_0800_8000_0000);
        for (int i = 0; i < 8; i++)
            send_sample(random_sample());
        drain();
    endtask

    task automatic test_random_typical(input int count);
        load_typical();
        for (int i = 0; i < count; i++)
        begin
            quiet_stretch = (i >= count / 3) && (i < count / 2);
            send_sample(random_sample());
        end
        quiet_stretch = 1'b0;
        drain();
    endtask

    task automatic test_random_coeffs(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            write_reg(REG_TEMP_COEFFS, {$urandom, $urandom});
            write_reg(REG_PRESS_COEFFS_LOW, {$urandom, $urandom});
            write_reg(REG_PRESS_COEFFS_HI, {$urandom, $urandom});
            write_reg(REG_PRESS_COEFF_NINE, {32'($urandom), 32'($urandom)});
            write_reg(REG_HUMID_COEFFS, {$urandom, $urandom});
            write_reg(REG_HUMID_ENABLE, 64'($urandom_range(3) != 0));
            for (int i = 0; i < per_phase; i++)
                send_sample(random_sample());
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        write_enable = 1'b0;
        write_index = '0;
        write_data = '0;
        cal_temp = '0;
        cal_press_low = '0;
        cal_press_high = '0;
        cal_p9 = '0;
        cal_humid = '0;
        cal_humid_en = 1'b0;
        mismatch_count = 0;
        unexpected_count = 0;
        idle_cycles = 0;
        quiet_stretch = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_random_typical(900);
        test_random_coeffs(10, 70);

        if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
